[rtl/rtb_pkg.sv]
// Shared types and codes for the reloadable timer bank.
// Holds the command and result beat structs, command codes and unit operations.
// No dependencies.
package rtb_pkg;

	localparam int DEF_TIMERS      = 8;
	localparam int DEF_COUNT_WIDTH = 16;
	localparam int ANSWER_W        = 16;

	typedef enum logic [3:0] {
		CMD_LOAD      = 4'd0,
		CMD_TICK      = 4'd1,
		CMD_TICK_ON   = 4'd2,
		CMD_TICK_OFF  = 4'd3,
		CMD_ENABLE    = 4'd4,
		CMD_DISABLE   = 4'd5,
		CMD_RESET     = 4'd6,
		CMD_RESET_EN  = 4'd7,
		CMD_SET       = 4'd8,
		CMD_RESET_ALL = 4'd9,
		CMD_FINALIZE  = 4'd10,
		CMD_INIT      = 4'd11
	} cmd_code_t;

	typedef enum logic [1:0] {
		KIND_FIRED  = 2'd0,
		KIND_DONE   = 2'd1,
		KIND_ANSWER = 2'd2
	} kind_t;

	// Operations of the shared per-timer update unit.
	typedef enum logic [2:0] {
		OP_TICK,
		OP_LOAD,
		OP_ENABLE,
		OP_DISABLE,
		OP_RESET,
		OP_RESET_EN,
		OP_SET,
		OP_FINAL
	} op_t;

	typedef struct packed {
		logic enabled;
		logic reload_in_use;
		logic is_variable;
		logic starts_on;
	} flags_t;

	typedef struct packed {
		logic [3:0]  command;
		logic [2:0]  timer_index;
		logic [15:0] value;
		logic [15:0] max_value;
		logic        variable_flag;
		logic        default_on_flag;
	} cmd_t;

	typedef struct packed {
		logic [1:0]          kind;
		logic [2:0]          fired_index;
		logic [ANSWER_W-1:0] answer;
		logic                last;
	} res_t;

endpackage

[rtl/rtb_store.sv]
// Per-timer state table: counters, reload values, descriptors and flags.
// One read port and one write port at the same address; cleared by reset.
// Depends on rtb_pkg.
module rtb_store #(
	parameter int TIMERS      = rtb_pkg::DEF_TIMERS,
	parameter int COUNT_WIDTH = rtb_pkg::DEF_COUNT_WIDTH,
	parameter int IW          = (TIMERS > 1) ? $clog2(TIMERS) : 1
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic [IW-1:0]          addr,
	input  logic                   wr_en,
	input  rtb_pkg::flags_t        wr_flags,
	input  logic [COUNT_WIDTH-1:0] wr_count,
	input  logic [COUNT_WIDTH-1:0] wr_reload,
	input  logic [COUNT_WIDTH-1:0] wr_deflt,
	input  logic [COUNT_WIDTH-1:0] wr_maxim,
	output rtb_pkg::flags_t        rd_flags,
	output logic [COUNT_WIDTH-1:0] rd_count,
	output logic [COUNT_WIDTH-1:0] rd_reload,
	output logic [COUNT_WIDTH-1:0] rd_deflt,
	output logic [COUNT_WIDTH-1:0] rd_maxim
);
	import rtb_pkg::*;

	flags_t                 flags_q  [TIMERS];
	logic [COUNT_WIDTH-1:0] count_q  [TIMERS];
	logic [COUNT_WIDTH-1:0] reload_q [TIMERS];
	logic [COUNT_WIDTH-1:0] deflt_q  [TIMERS];
	logic [COUNT_WIDTH-1:0] maxim_q  [TIMERS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TIMERS; i++) begin
				flags_q[i]  <= '0;
				count_q[i]  <= '0;
				reload_q[i] <= '0;
				deflt_q[i]  <= '0;
				maxim_q[i]  <= '0;
			end
		end else if (wr_en) begin
			flags_q[addr]  <= wr_flags;
			count_q[addr]  <= wr_count;
			reload_q[addr] <= wr_reload;
			deflt_q[addr]  <= wr_deflt;
			maxim_q[addr]  <= wr_maxim;
		end
	end

	assign rd_flags  = flags_q[addr];
	assign rd_count  = count_q[addr];
	assign rd_reload = reload_q[addr];
	assign rd_deflt  = deflt_q[addr];
	assign rd_maxim  = maxim_q[addr];

endmodule

[rtl/rtb_unit.sv]
// Shared per-timer update unit: decrement, zero test, clamp and reload.
// Computes the next state of the one timer the sequencer currently addresses.
// Depends on rtb_pkg.
module rtb_unit #(
	parameter int COUNT_WIDTH = rtb_pkg::DEF_COUNT_WIDTH
) (
	input  rtb_pkg::op_t           op,
	input  rtb_pkg::flags_t        flags,
	input  logic [COUNT_WIDTH-1:0] count,
	input  logic [COUNT_WIDTH-1:0] reload,
	input  logic [COUNT_WIDTH-1:0] deflt,
	input  logic [COUNT_WIDTH-1:0] maxim,
	input  logic [COUNT_WIDTH-1:0] val,
	input  logic [COUNT_WIDTH-1:0] maxv,
	input  logic                   vflag,
	input  logic                   onflag,
	output rtb_pkg::flags_t        flags_n,
	output logic [COUNT_WIDTH-1:0] count_n,
	output logic [COUNT_WIDTH-1:0] reload_n,
	output logic [COUNT_WIDTH-1:0] deflt_n,
	output logic [COUNT_WIDTH-1:0] maxim_n,
	output logic                   fire
);
	import rtb_pkg::*;

	logic [COUNT_WIDTH-1:0] clamp_in;
	logic [COUNT_WIDTH-1:0] clamp_lo;
	logic [COUNT_WIDTH-1:0] clamped;
	logic [COUNT_WIDTH-1:0] dec;

	// One clamp serves tick, disable and set; the maximum wins over the default.
	assign clamp_in = (op == OP_SET) ? val : reload;
	assign clamp_lo = (clamp_in < deflt) ? deflt : clamp_in;
	assign clamped  = (clamp_lo > maxim) ? maxim : clamp_lo;
	assign dec      = (count != '0) ? count - 1'b1 : count;

	always_comb begin
		flags_n  = flags;
		count_n  = count;
		reload_n = reload;
		deflt_n  = deflt;
		maxim_n  = maxim;
		fire     = 1'b0;
		case (op)
			OP_TICK: begin
				if (flags.enabled) begin
					count_n = dec;
					if (dec == '0) begin
						fire = 1'b1;
						if (flags.is_variable && flags.reload_in_use) begin
							reload_n = clamped;
							count_n  = clamped;
						end else begin
							count_n = deflt;
						end
					end
				end
			end
			OP_LOAD: begin
				deflt_n             = val;
				maxim_n             = maxv;
				flags_n.is_variable = vflag;
				flags_n.starts_on   = onflag;
			end
			OP_ENABLE: begin
				flags_n.enabled = 1'b1;
			end
			OP_DISABLE: begin
				flags_n.enabled = 1'b0;
				if (flags.reload_in_use) begin
					reload_n = clamped;
					count_n  = clamped;
				end else begin
					count_n = deflt;
				end
			end
			OP_RESET, OP_RESET_EN: begin
				count_n               = deflt;
				reload_n              = deflt;
				flags_n.enabled       = (op == OP_RESET_EN) ? 1'b1 : flags.starts_on;
				flags_n.reload_in_use = flags.is_variable;
			end
			OP_SET: begin
				if (flags.is_variable) begin
					reload_n = clamped;
					count_n  = clamped;
				end
			end
			OP_FINAL: begin
				flags_n.enabled = 1'b0;
			end
			default: begin
			end
		endcase
	end

endmodule

[rtl/reloadable_timer_bank_top.sv]
// Top level of the reloadable timer bank: command sequencer and result register.
// Instantiates rtb_store and rtb_unit; depends on rtb_pkg.
//
//   Channel   Ports                      Handshake
//   command   start, busy, cmd           beat taken when start is high and busy is low
//   result    valid, result              one-cycle strobe, no back-pressure
//
// A tick while ticks are allowed, reset all, finalize and init walk the bank one
// timer per cycle through the shared update unit, then give the done beat.
// Single-timer commands pass through the unit once, others go straight to the
// done beat. Fired beats come during the walk, then the done beat; busy falls with it.
// Reset clears all timer state and tick handling at once. Results cannot stall.
module reloadable_timer_bank_top #(
	parameter int TIMERS      = rtb_pkg::DEF_TIMERS,
	parameter int COUNT_WIDTH = rtb_pkg::DEF_COUNT_WIDTH
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  rtb_pkg::cmd_t cmd,
	output logic          valid,
	output rtb_pkg::res_t result
);
	import rtb_pkg::*;

	localparam int IW = (TIMERS > 1) ? $clog2(TIMERS) : 1;
	localparam logic [IW-1:0] LAST = IW'(TIMERS - 1);

	typedef enum logic [1:0] {
		S_IDLE,
		S_WALK,
		S_DONE
	} state_t;

	state_t        state_q;
	cmd_t          cmd_q;
	op_t           op_q;
	logic          all_q;
	logic [IW-1:0] ptr_q;
	logic          tick_allowed_q;
	logic          valid_q;
	res_t          result_q;
	logic [ANSWER_W-1:0] answer_q;

	flags_t                 rd_flags, wr_flags;
	logic [COUNT_WIDTH-1:0] rd_count, rd_reload, rd_deflt, rd_maxim;
	logic [COUNT_WIDTH-1:0] wr_count, wr_reload, wr_deflt, wr_maxim;
	logic                   fire;
	logic                   wr_en;

	logic accept;
	logic idx_ok;
	op_t  op_d;
	logic single_d;
	logic walk_all_d;

	assign accept = start && (state_q == S_IDLE);
	assign idx_ok = 32'(cmd.timer_index) < TIMERS;

	always_comb begin
		op_d       = OP_TICK;
		single_d   = 1'b0;
		walk_all_d = 1'b0;
		case (cmd.command)
			CMD_LOAD:      begin op_d = OP_LOAD;     single_d = 1'b1; end
			CMD_TICK:      begin op_d = OP_TICK;     walk_all_d = tick_allowed_q; end
			CMD_ENABLE:    begin op_d = OP_ENABLE;   single_d = 1'b1; end
			CMD_DISABLE:   begin op_d = OP_DISABLE;  single_d = 1'b1; end
			CMD_RESET:     begin op_d = OP_RESET;    single_d = 1'b1; end
			CMD_RESET_EN:  begin op_d = OP_RESET_EN; single_d = 1'b1; end
			CMD_SET:       begin op_d = OP_SET;      single_d = 1'b1; end
			CMD_RESET_ALL: begin op_d = OP_RESET;    walk_all_d = 1'b1; end
			CMD_FINALIZE:  begin op_d = OP_FINAL;    walk_all_d = 1'b1; end
			CMD_INIT:      begin op_d = OP_RESET;    walk_all_d = 1'b1; end
			default: begin
			end
		endcase
	end

	assign wr_en = (state_q == S_WALK);

	rtb_store #(
		.TIMERS      (TIMERS),
		.COUNT_WIDTH (COUNT_WIDTH),
		.IW          (IW)
	) u_store (
		.clk       (clk),
		.arst_n    (arst_n),
		.addr      (ptr_q),
		.wr_en     (wr_en),
		.wr_flags  (wr_flags),
		.wr_count  (wr_count),
		.wr_reload (wr_reload),
		.wr_deflt  (wr_deflt),
		.wr_maxim  (wr_maxim),
		.rd_flags  (rd_flags),
		.rd_count  (rd_count),
		.rd_reload (rd_reload),
		.rd_deflt  (rd_deflt),
		.rd_maxim  (rd_maxim)
	);

	rtb_unit #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_unit (
		.op       (op_q),
		.flags    (rd_flags),
		.count    (rd_count),
		.reload   (rd_reload),
		.deflt    (rd_deflt),
		.maxim    (rd_maxim),
		.val      (COUNT_WIDTH'(cmd_q.value)),
		.maxv     (COUNT_WIDTH'(cmd_q.max_value)),
		.vflag    (cmd_q.variable_flag),
		.onflag   (cmd_q.default_on_flag),
		.flags_n  (wr_flags),
		.count_n  (wr_count),
		.reload_n (wr_reload),
		.deflt_n  (wr_deflt),
		.maxim_n  (wr_maxim),
		.fire     (fire)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			tick_allowed_q <= 1'b0;
			valid_q        <= 1'b0;
			all_q          <= 1'b0;
			ptr_q          <= '0;
			op_q           <= OP_TICK;
			cmd_q          <= '0;
			answer_q       <= '0;
			result_q       <= '0;
		end else begin
			valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						cmd_q    <= cmd;
						op_q     <= op_d;
						all_q    <= walk_all_d;
						answer_q <= '0;
						ptr_q    <= walk_all_d ? '0 : IW'(cmd.timer_index);
						if (cmd.command == CMD_TICK_ON) begin
							tick_allowed_q <= 1'b1;
						end
						if (cmd.command == CMD_TICK_OFF || cmd.command == CMD_INIT) begin
							tick_allowed_q <= 1'b0;
						end
						if (walk_all_d || (single_d && idx_ok)) begin
							state_q <= S_WALK;
						end else begin
							state_q <= S_DONE;
						end
					end
				end
				S_WALK: begin
					if (op_q == OP_TICK && fire) begin
						valid_q              <= 1'b1;
						result_q.kind        <= KIND_FIRED;
						result_q.fired_index <= 3'(ptr_q);
						result_q.answer      <= '0;
						result_q.last        <= 1'b0;
					end
					if (op_q == OP_SET && rd_flags.is_variable) begin
						answer_q <= ANSWER_W'(wr_reload);
					end
					if (!all_q || ptr_q == LAST) begin
						state_q <= S_DONE;
					end else begin
						ptr_q <= ptr_q + 1'b1;
					end
				end
				S_DONE: begin
					valid_q              <= 1'b1;
					result_q.kind        <= (cmd_q.command == CMD_SET) ? KIND_ANSWER : KIND_DONE;
					result_q.fired_index <= (cmd_q.command == CMD_TICK) ? 3'd0 : cmd_q.timer_index;
					result_q.answer      <= answer_q;
					result_q.last        <= 1'b1;
					state_q              <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy   = (state_q != S_IDLE);
	assign valid  = valid_q;
	assign result = result_q;

endmodule

[sim/reloadable_timer_bank_top_tb.sv]
// Self-checking testbench for reloadable_timer_bank_top: directed cases, then random command traffic.
// Expected beats come from a behavioral model of the timer bank kept inside this file.
// Depends on rtb_pkg and the timer bank RTL.
`timescale 1ns / 100ps

module reloadable_timer_bank_top_tb;
	import rtb_pkg::*;

	localparam int TIMERS = DEF_TIMERS;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	cmd_t cmd;
	logic valid;
	res_t result;

	reloadable_timer_bank_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.valid  (valid),
		.result (result)
	);

	// Model of the bank: counters, descriptors and tick handling.
	bit [15:0] tmr_count [TIMERS];
	bit [15:0] tmr_reload [TIMERS];
	bit [15:0] tmr_dflt [TIMERS];
	bit [15:0] tmr_max [TIMERS];
	bit        tmr_enabled [TIMERS];
	bit        tmr_uses_reload [TIMERS];
	bit        tmr_variable [TIMERS];
	bit        tmr_start_on [TIMERS];
	bit        ticks_on;

	res_t        pending_beats [$];
	int unsigned mismatches;
	int unsigned commands_sent;
	int unsigned beats_checked;
	int unsigned fires_seen;
	int unsigned answers_seen;
	bit          gaps_on;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	task automatic report_mismatch(input string what);
		if (mismatches < 30)
			$display("%0t ns: mismatch: %s", $time, what);
		mismatches++;
	endtask

	function automatic res_t make_beat(kind_t kind, int unsigned idx, logic [15:0] answer,
		logic last);
		res_t b;
		b.kind        = kind;
		b.fired_index = 3'(idx);
		b.answer      = answer;
		b.last        = last;
		return b;
	endfunction

	// The maximum wins when it lies below the default timeout.
	function automatic void clamp_reload(int unsigned t);
		if (tmr_reload[t] < tmr_dflt[t])
			tmr_reload[t] = tmr_dflt[t];
		if (tmr_reload[t] > tmr_max[t])
			tmr_reload[t] = tmr_max[t];
	endfunction

	function automatic void reset_timer(int unsigned t);
		tmr_count[t]       = tmr_dflt[t];
		tmr_reload[t]      = tmr_dflt[t];
		tmr_enabled[t]     = tmr_start_on[t];
		tmr_uses_reload[t] = tmr_variable[t];
	endfunction

	// Updates the model for one accepted command and queues the beats it must produce.
	function automatic void apply_command(cmd_t c);
		int unsigned idx;
		logic [15:0] answer;
		idx = c.timer_index;
		case (cmd_code_t'(c.command))
			CMD_LOAD: begin
				tmr_dflt[idx]     = c.value;
				tmr_max[idx]      = c.max_value;
				tmr_variable[idx] = c.variable_flag;
				tmr_start_on[idx] = c.default_on_flag;
			end
			CMD_TICK: begin
				if (ticks_on) begin
					for (int unsigned t = 0; t < TIMERS; t++) begin
						if (tmr_enabled[t]) begin
							if (tmr_count[t] != 0)
								tmr_count[t]--;
							if (tmr_count[t] == 0) begin
								if (tmr_variable[t] && tmr_uses_reload[t]) begin
									clamp_reload(t);
									tmr_count[t] = tmr_reload[t];
								end else begin
									tmr_count[t] = tmr_dflt[t];
								end
								pending_beats.push_back(make_beat(KIND_FIRED, t, 16'h0, 1'b0));
							end
						end
					end
				end
				pending_beats.push_back(make_beat(KIND_DONE, 0, 16'h0, 1'b1));
				return;
			end
			CMD_TICK_ON:  ticks_on = 1'b1;
			CMD_TICK_OFF: ticks_on = 1'b0;
			CMD_ENABLE:   tmr_enabled[idx] = 1'b1;
			CMD_DISABLE: begin
				tmr_enabled[idx] = 1'b0;
				if (tmr_uses_reload[idx]) begin
					clamp_reload(idx);
					tmr_count[idx] = tmr_reload[idx];
				end else begin
					tmr_count[idx] = tmr_dflt[idx];
				end
			end
			CMD_RESET: reset_timer(idx);
			CMD_RESET_EN: begin
				reset_timer(idx);
				tmr_enabled[idx] = 1'b1;
			end
			CMD_SET: begin
				answer = 16'h0;
				if (tmr_variable[idx]) begin
					tmr_reload[idx] = c.value;
					clamp_reload(idx);
					tmr_count[idx] = tmr_reload[idx];
					answer = tmr_reload[idx];
				end
				pending_beats.push_back(make_beat(KIND_ANSWER, idx, answer, 1'b1));
				return;
			end
			CMD_RESET_ALL: begin
				for (int unsigned t = 0; t < TIMERS; t++)
					reset_timer(t);
			end
			CMD_FINALIZE: begin
				for (int unsigned t = 0; t < TIMERS; t++)
					tmr_enabled[t] = 1'b0;
			end
			CMD_INIT: begin
				for (int unsigned t = 0; t < TIMERS; t++)
					reset_timer(t);
				ticks_on = 1'b0;
			end
			default: ;
		endcase
		pending_beats.push_back(make_beat(KIND_DONE, idx, 16'h0, 1'b1));
	endfunction

	// Results cannot be held off, so every strobe is checked at the edge that ends it.
	always @(posedge clk) begin : check_beats
		res_t want;
		if (arst_n && valid) begin
			if (pending_beats.size() == 0) begin
				report_mismatch($sformatf("unexpected beat kind %0d index %0d",
					result.kind, result.fired_index));
			end else begin
				want = pending_beats.pop_front();
				beats_checked++;
				if (want.kind == KIND_FIRED)
					fires_seen++;
				if (want.kind == KIND_ANSWER)
					answers_seen++;
				if (result.kind !== want.kind)
					report_mismatch($sformatf("kind %0d, expected %0d", result.kind, want.kind));
				if (result.fired_index !== want.fired_index)
					report_mismatch($sformatf("index %0d, expected %0d",
						result.fired_index, want.fired_index));
				if (result.answer !== want.answer)
					report_mismatch($sformatf("answer %0h, expected %0h",
						result.answer, want.answer));
				if (result.last !== want.last)
					report_mismatch($sformatf("last %0b, expected %0b", result.last, want.last));
			end
		end
	end

	// Offers one command beat, dropping start on random cycles, until it is taken.
	// The values read right after the edge are the ones the design sampled at it.
	task automatic send_command(input cmd_t c);
		bit taken;
		taken = 1'b0;
		while (!taken) begin
			if (gaps_on && $urandom_range(99) < 22) begin
				start <= 1'b0;
			end else begin
				start <= 1'b1;
				cmd   <= c;
			end
			@(posedge clk);
			taken = start && !busy;
		end
		apply_command(c);
		commands_sent++;
	endtask

	function automatic cmd_t make_cmd(cmd_code_t code, int unsigned idx = 0,
		logic [15:0] value = 16'h0, logic [15:0] max_value = 16'h0,
		logic vflag = 1'b0, logic onflag = 1'b0);
		cmd_t c;
		c.command         = code;
		c.timer_index     = 3'(idx);
		c.value           = value;
		c.max_value       = max_value;
		c.variable_flag   = vflag;
		c.default_on_flag = onflag;
		return c;
	endfunction

	// Mostly short timeouts so timers fire often; now and then a full-width value.
	function automatic cmd_t random_fields(cmd_code_t code);
		cmd_t c;
		c.command     = code;
		c.timer_index = 3'($urandom_range(TIMERS - 1));
		c.value       = ($urandom_range(7) == 0) ? 16'($urandom) : 16'($urandom_range(6));
		if ($urandom_range(7) == 0)
			c.max_value = 16'($urandom);
		else
			c.max_value = c.value + 16'($urandom_range(6));
		c.variable_flag   = 1'($urandom);
		c.default_on_flag = 1'($urandom);
		return c;
	endfunction

	task automatic test_ticks_from_reset;
		send_command(make_cmd(CMD_TICK));
		send_command(make_cmd(CMD_TICK_ON));
		// A timer enabled with an all-zero descriptor fires on every tick.
		send_command(make_cmd(CMD_ENABLE, 3));
		send_command(make_cmd(CMD_TICK));
	endtask

	task automatic test_descriptor_extremes;
		send_command(make_cmd(CMD_LOAD, 0, 16'h0001, 16'hFFFF, 1'b1, 1'b1));
		send_command(make_cmd(CMD_LOAD, 7, 16'hFFFF, 16'h0000, 1'b1, 1'b0));
		send_command(make_cmd(CMD_LOAD, 5, 16'h0002, 16'h0004, 1'b0, 1'b1));
		send_command(make_cmd(CMD_INIT));
		send_command(make_cmd(CMD_TICK));
		send_command(make_cmd(CMD_TICK_ON));
		send_command(make_cmd(CMD_TICK));
	endtask

	task automatic test_set_timeout;
		send_command(make_cmd(CMD_SET, 0, 16'h0000));
		// Timer 7 has its maximum below its default, so the maximum is answered.
		send_command(make_cmd(CMD_SET, 7, 16'h1234));
		send_command(make_cmd(CMD_SET, 5, 16'h0003));
		send_command(make_cmd(CMD_SET, 0, 16'hFFFF));
	endtask

	task automatic test_enable_controls;
		send_command(make_cmd(CMD_RESET_EN, 7));
		send_command(make_cmd(CMD_TICK));
		send_command(make_cmd(CMD_DISABLE, 7));
		send_command(make_cmd(CMD_RESET, 0));
		send_command(make_cmd(CMD_FINALIZE));
		send_command(make_cmd(CMD_TICK));
		send_command(make_cmd(CMD_RESET_ALL));
		send_command(make_cmd(CMD_TICK_OFF));
		send_command(make_cmd(CMD_TICK));
	endtask

	// Episodes of init, descriptor loads, reset all and tick on, followed by mixed
	// traffic dominated by ticks. Two episodes run with no pauses at all.
	task automatic test_random_traffic(input int unsigned n_items);
		int unsigned first;
		int unsigned episode;
		int unsigned r;
		cmd_t c;
		first   = commands_sent;
		episode = 0;
		while (commands_sent - first < n_items) begin
			gaps_on = (episode != 2 && episode != 3);
			send_command(random_fields(CMD_INIT));
			for (int unsigned t = 0; t < TIMERS; t++) begin
				c = random_fields(CMD_LOAD);
				c.timer_index     = 3'(t);
				c.default_on_flag = ($urandom_range(3) != 0);
				send_command(c);
			end
			send_command(random_fields(CMD_RESET_ALL));
			send_command(random_fields(CMD_TICK_ON));
			repeat ($urandom_range(45, 25)) begin
				r = $urandom_range(99);
				if (r < 45)      c = random_fields(CMD_TICK);
				else if (r < 55) c = random_fields(CMD_SET);
				else if (r < 62) c = random_fields(CMD_ENABLE);
				else if (r < 68) c = random_fields(CMD_DISABLE);
				else if (r < 73) c = random_fields(CMD_RESET);
				else if (r < 80) c = random_fields(CMD_RESET_EN);
				else if (r < 86) c = random_fields(CMD_LOAD);
				else if (r < 90) c = random_fields(CMD_TICK_ON);
				else if (r < 93) c = random_fields(CMD_TICK_OFF);
				else if (r < 95) c = random_fields(CMD_RESET_ALL);
				else if (r < 97) c = random_fields(CMD_FINALIZE);
				else             c = random_fields(CMD_INIT);
				send_command(c);
			end
			episode++;
		end
		gaps_on = 1'b1;
	endtask

	initial begin
		int unsigned waited;
		arst_n  = 1'b0;
		start   = 1'b0;
		cmd     = '0;
		gaps_on = 1'b1;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_ticks_from_reset();
		test_descriptor_extremes();
		test_set_timeout();
		test_enable_controls();
		test_random_traffic(420);

		start  <= 1'b0;
		waited = 0;
		while (pending_beats.size() != 0 && waited < 2000) begin
			@(posedge clk);
			waited++;
		end
		repeat (2 * TIMERS + 8) @(posedge clk);
		if (pending_beats.size() != 0)
			report_mismatch($sformatf("%0d beats never arrived", pending_beats.size()));

		$display("Sent %0d commands; checked %0d result beats, %0d of them timer fires",
			commands_sent, beats_checked, fires_seen);
		$display("and %0d timeout answers; %0d mismatches.", answers_seen, mismatches);
		if (mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	initial begin
		#5ms;
		$display("Run timed out.");
		$display("CHECK FAILED");
		$finish;
	end

endmodule
